// ===== hw/rtl/fgks_pkg.sv =====
package fgks_pkg;

	localparam int NODE_W  = 10;
	localparam int SIZE_W  = 11;
	localparam int STEPS_W = 64;
	localparam int CNT_W   = 6;
	// generation tag kept beside each first-visit step; zero means cleared
	localparam int EPOCH_W = 8;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_WALK,
		ST_SUB,
		ST_MOD,
		ST_READ,
		ST_HOLD,
		ST_OUT
	} state_t;

endpackage

// ===== hw/rtl/functional_graph_kth_successor_unit.sv =====
// Load transfer: writes the successor table entry, no result. Query: a walk of W table steps (W = steps until the
// first repeated node, at most the table size; one table step per cycle), then the cycle length, a bit-serial
// remainder when K exceeds W, a history read and the output.
// One item at a time; a finished result may wait in the output register.
// arst_n clears control state; a tag-clearing sweep over all MAX_NODES tag entries follows reset
// and every 255th query, during which no item is taken.
module functional_graph_kth_successor_unit #(
	parameter int MAX_NODES = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fgks_pkg::SIZE_W-1:0]      cfg_wdata,      // table_size
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [87:0]                      s_axis_tdata,   // entry_index, entry_value, steps
	input  logic [0:0]                       s_axis_tuser,   // cmd
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [15:0]                      m_axis_tdata,   // final_node
	output logic [0:0]                       m_axis_tuser    // status
);

	localparam int AW = $clog2(MAX_NODES);
	localparam int SW = $clog2(MAX_NODES + 1);
	localparam int EW = fgks_pkg::EPOCH_W;
	localparam int TW = EW + SW;
	localparam int NW = fgks_pkg::NODE_W;
	localparam int KW = fgks_pkg::STEPS_W;
	localparam int CW = fgks_pkg::CNT_W;

	// input fields
	logic          cmd;
	logic [NW-1:0] entry_index;
	logic [NW-1:0] entry_value;
	logic [KW-1:0] steps;

	assign cmd         = s_axis_tuser[0];
	assign entry_index = s_axis_tdata[9:0];
	assign entry_value = s_axis_tdata[19:10];
	assign steps       = s_axis_tdata[83:20];

	// memories
	logic [NW-1:0] succ_mem [MAX_NODES];
	logic [TW-1:0] tag_mem  [MAX_NODES];
	logic [AW-1:0] hist_mem [MAX_NODES+1];

	logic          succ_we, succ_re;
	logic [AW-1:0] succ_wa, succ_ra;
	logic [NW-1:0] succ_wd, succ_rd_q;
	logic          tag_we, tag_re;
	logic [AW-1:0] tag_wa, tag_ra;
	logic [TW-1:0] tag_wd, tag_rd_q;
	logic          hist_we, hist_re;
	logic [SW-1:0] hist_wa, hist_ra;
	logic [AW-1:0] hist_wd, hist_rd_q;

	// control and datapath registers
	fgks_pkg::state_t state_q, state_d;
	logic [fgks_pkg::SIZE_W-1:0] size_q;
	logic [EW-1:0] ep_q, ep_d;
	logic [AW-1:0] clr_q, clr_d;
	logic          out_valid_q, out_valid_d;
	logic [NW-1:0] out_node_q, out_node_d;
	logic          out_err_q, out_err_d;
	logic [SW-1:0] lim_q, lim_d;
	logic [KW-1:0] k_q, k_d;
	logic [AW-1:0] c_q, c_d;
	logic [SW-1:0] s_q, s_d;
	logic          chk_q, chk_d;
	logic          fwd_q, fwd_d;
	logic [SW-1:0] fstep_q, fstep_d;
	logic [SW-1:0] w_q, w_d;
	logic [SW-1:0] mu_q, mu_d;
	logic [SW-1:0] len_q, len_d;
	logic [SW-1:0] rem_q, rem_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [SW-1:0] hidx_q, hidx_d;
	logic [NW-1:0] res_node_q, res_node_d;
	logic          res_err_q, res_err_d;

	// helpers
	logic          accept;
	logic          nxt_bad;
	logic          prev_seen;
	logic [SW-1:0] prev_step;
	logic [AW-1:0] nxt_node;
	logic          k_small;
	logic [SW:0]   rem_sh;
	logic [SW:0]   rem_n;

	assign s_axis_tready = (state_q == fgks_pkg::ST_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	assign nxt_node  = AW'(succ_rd_q);
	assign nxt_bad   = 32'(succ_rd_q) >= 32'(lim_q);
	assign prev_seen = chk_q && (fwd_q || tag_rd_q[TW-1 -: EW] == ep_q);
	assign prev_step = fwd_q ? fstep_q : tag_rd_q[SW-1:0];
	assign k_small   = (k_q[KW-1:SW] == '0) && (k_q[SW-1:0] <= w_q);
	assign rem_sh    = {rem_q, k_q[KW-1]};
	assign rem_n     = (rem_sh >= {1'b0, len_q}) ? rem_sh - {1'b0, len_q} : rem_sh;

	always_comb begin
		state_d     = state_q;
		ep_d        = ep_q;
		clr_d       = clr_q;
		out_valid_d = out_valid_q && !m_axis_tready;
		out_node_d  = out_node_q;
		out_err_d   = out_err_q;
		lim_d       = lim_q;
		k_d         = k_q;
		c_d         = c_q;
		s_d         = s_q;
		chk_d       = chk_q;
		fwd_d       = fwd_q;
		fstep_d     = fstep_q;
		w_d         = w_q;
		mu_d        = mu_q;
		len_d       = len_q;
		rem_d       = rem_q;
		cnt_d       = cnt_q;
		hidx_d      = hidx_q;
		res_node_d  = res_node_q;
		res_err_d   = res_err_q;

		succ_we = 1'b0;
		succ_wa = AW'(entry_index);
		succ_wd = entry_value;
		succ_re = 1'b0;
		succ_ra = nxt_node;
		tag_we  = 1'b0;
		tag_wa  = c_q;
		tag_wd  = {ep_q, s_q};
		tag_re  = 1'b0;
		tag_ra  = nxt_node;
		hist_we = 1'b0;
		hist_wa = s_q + SW'(1);
		hist_wd = nxt_node;
		hist_re = 1'b0;
		hist_ra = hidx_q;

		unique case (state_q)
			fgks_pkg::ST_CLEAR: begin
				tag_we = 1'b1;
				tag_wa = clr_q;
				tag_wd = '0;
				clr_d  = clr_q + AW'(1);
				if (clr_q == AW'(MAX_NODES - 1))
					state_d = fgks_pkg::ST_IDLE;
			end
			fgks_pkg::ST_IDLE: begin
				if (accept) begin
					if (cmd == fgks_pkg::CMD_LOAD) begin
						succ_we = 32'(entry_index) < MAX_NODES;
					end else begin
						k_d   = steps;
						lim_d = (32'(size_q) > MAX_NODES) ? SW'(MAX_NODES) : SW'(size_q);
						if (size_q == '0) begin
							res_node_d = '0;
							res_err_d  = 1'b1;
							state_d    = fgks_pkg::ST_OUT;
						end else begin
							state_d = fgks_pkg::ST_START;
						end
					end
				end
			end
			fgks_pkg::ST_START: begin
				succ_re = 1'b1;
				succ_ra = '0;
				tag_we  = 1'b1;
				tag_wa  = '0;
				tag_wd  = {ep_q, SW'(0)};
				hist_we = 1'b1;
				hist_wa = '0;
				hist_wd = '0;
				c_d     = '0;
				s_d     = '0;
				chk_d   = 1'b0;
				fwd_d   = 1'b0;
				state_d = fgks_pkg::ST_WALK;
			end
			fgks_pkg::ST_WALK: begin
				// the node at step s_q is checked while its successor is already in hand
				if (prev_seen) begin
					w_d     = s_q;
					mu_d    = prev_step;
					state_d = fgks_pkg::ST_SUB;
				end else begin
					tag_we = chk_q;
					if (nxt_bad) begin
						res_node_d = '0;
						res_err_d  = 1'b1;
						state_d    = fgks_pkg::ST_OUT;
					end else begin
						hist_we = 1'b1;
						tag_re  = 1'b1;
						succ_re = 1'b1;
						c_d     = nxt_node;
						s_d     = s_q + SW'(1);
						chk_d   = 1'b1;
						// same-cycle write to the entry being read: forward it
						fwd_d   = chk_q && (nxt_node == c_q);
						fstep_d = s_q;
					end
				end
			end
			fgks_pkg::ST_SUB: begin
				len_d = w_q - mu_q;
				if (k_small) begin
					hidx_d  = k_q[SW-1:0];
					state_d = fgks_pkg::ST_READ;
				end else begin
					k_d     = k_q - KW'(w_q);
					rem_d   = '0;
					cnt_d   = '0;
					state_d = fgks_pkg::ST_MOD;
				end
			end
			fgks_pkg::ST_MOD: begin
				rem_d = rem_n[SW-1:0];
				k_d   = {k_q[KW-2:0], 1'b0};
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == CW'(KW - 1)) begin
					hidx_d  = mu_q + rem_n[SW-1:0];
					state_d = fgks_pkg::ST_READ;
				end
			end
			fgks_pkg::ST_READ: begin
				hist_re = 1'b1;
				state_d = fgks_pkg::ST_HOLD;
			end
			fgks_pkg::ST_HOLD: begin
				res_node_d = NW'(hist_rd_q);
				res_err_d  = 1'b0;
				state_d    = fgks_pkg::ST_OUT;
			end
			fgks_pkg::ST_OUT: begin
				if (!out_valid_q || m_axis_tready) begin
					out_valid_d = 1'b1;
					out_node_d  = res_node_q;
					out_err_d   = res_err_q;
					if (ep_q == '1) begin
						ep_d    = EW'(1);
						clr_d   = '0;
						state_d = fgks_pkg::ST_CLEAR;
					end else begin
						ep_d    = ep_q + EW'(1);
						state_d = fgks_pkg::ST_IDLE;
					end
				end
			end
			default: state_d = fgks_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fgks_pkg::ST_CLEAR;
			size_q      <= fgks_pkg::SIZE_W'(1024);
			ep_q        <= EW'(1);
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			ep_q        <= ep_d;
			clr_q       <= clr_d;
			out_valid_q <= out_valid_d;
			if (cfg_we)
				size_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		out_node_q <= out_node_d;
		out_err_q  <= out_err_d;
		lim_q      <= lim_d;
		k_q        <= k_d;
		c_q        <= c_d;
		s_q        <= s_d;
		chk_q      <= chk_d;
		fwd_q      <= fwd_d;
		fstep_q    <= fstep_d;
		w_q        <= w_d;
		mu_q       <= mu_d;
		len_q      <= len_d;
		rem_q      <= rem_d;
		cnt_q      <= cnt_d;
		hidx_q     <= hidx_d;
		res_node_q <= res_node_d;
		res_err_q  <= res_err_d;
	end

	always_ff @(posedge clk) begin
		if (succ_we)
			succ_mem[succ_wa] <= succ_wd;
		if (succ_re)
			succ_rd_q <= succ_mem[succ_ra];
	end

	always_ff @(posedge clk) begin
		if (tag_we)
			tag_mem[tag_wa] <= tag_wd;
		if (tag_re)
			tag_rd_q <= tag_mem[tag_ra];
	end

	always_ff @(posedge clk) begin
		if (hist_we)
			hist_mem[hist_wa] <= hist_wd;
		if (hist_re)
			hist_rd_q <= hist_mem[hist_ra];
	end

	assign m_axis_tvalid   = out_valid_q;
	assign m_axis_tdata    = {6'b0, out_node_q};
	assign m_axis_tuser[0] = out_err_q;

endmodule
